FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define CHK_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/jans_pkg.sv
package jans_pkg;

    // Fixed-point constants
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [23:0] ONE_Q16_24  = 24'd65536;
    localparam logic [19:0] US_PER_S    = 20'd1000000;

    // Register reset values
    localparam logic [16:0] RST_EMA_ALPHA = 17'd13107;
    localparam logic [30:0] RST_JERK_LIM  = 31'd3276800;
    localparam logic [30:0] RST_ANG_LIM   = 31'd655360;
    localparam logic [23:0] RST_CEILING   = 24'd655360;

    // Register indexes
    localparam int          CFG_IDX_W       = 8;
    localparam logic [7:0]  REG_EMA_ALPHA   = 8'd0;
    localparam logic [7:0]  REG_JERK_LIMIT  = 8'd1;
    localparam logic [7:0]  REG_ANG_LIMIT   = 8'd2;
    localparam logic [7:0]  REG_CEILING     = 8'd3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Sum of squared average changes for both groups, plus interval
    typedef struct packed {
        logic [65:0] acc_sq;
        logic [65:0] gyr_sq;
        logic [19:0] dt;
    } qent_t;

    // Lane status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } lane_stat_t;

    // Lane control from the top level
    typedef struct packed {
        logic start;
        logic ack;
    } lane_ctl_t;

endpackage

FILE: hw/rtl/jans_fifo.sv
module jans_fifo #(
    parameter int DEPTH = jans_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  jans_pkg::qent_t push_data,
    output logic            full,
    input  logic            pop,
    output jans_pkg::qent_t head,
    output logic            empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jans_pkg::qent_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/jans_front.sv
module jans_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [215:0]    s_tdata,
    input  logic [16:0]     alpha,
    output logic            push,
    output jans_pkg::qent_t push_data,
    input  logic            queue_full
);
    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_DIF, F_SQR, F_ACC, F_PUSH
    } front_state_t;

    front_state_t        state_reg, state_next;
    logic                primed_reg, primed_next;
    logic [2:0]          axis_reg, axis_next;
    logic [31:0]         smp_reg [6];
    logic [31:0]         smp_next [6];
    logic [31:0]         avg_reg [6];
    logic [31:0]         avg_next [6];
    logic [19:0]         dt_reg, dt_next;
    logic signed [50:0]  p_reg, p_next;
    logic [32:0]         dmag_reg, dmag_next;
    logic [65:0]         sq_reg, sq_next;
    logic [65:0]         sum_reg, sum_next;
    logic [65:0]         asum_reg, asum_next;

    logic [16:0]         alpha_eff;
    logic signed [32:0]  diff;
    logic signed [50:0]  p_rnd;
    logic signed [34:0]  d;
    logic [34:0]         d_abs;
    logic                accept;

    assign s_tready  = (state_reg == F_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign alpha_eff = (alpha > jans_pkg::ONE_Q16) ? jans_pkg::ONE_Q16 : alpha;
    assign push      = (state_reg == F_PUSH);
    assign push_data = '{acc_sq: asum_reg, gyr_sq: sum_reg, dt: dt_reg};

    // EMA step: change d = floor((alpha*(x-avg) + half) / 2^16)
    assign diff  = $signed({smp_reg[axis_reg][31], smp_reg[axis_reg]})
                 - $signed({avg_reg[axis_reg][31], avg_reg[axis_reg]});
    assign p_rnd = p_reg + 51'sd32768;
    assign d     = p_rnd[50:16];
    assign d_abs = d[34] ? 35'(-d) : 35'(d);

    always_comb begin
        state_next  = state_reg;
        primed_next = primed_reg;
        axis_next   = axis_reg;
        smp_next    = smp_reg;
        avg_next    = avg_reg;
        dt_next     = dt_reg;
        p_next      = p_reg;
        dmag_next   = dmag_reg;
        sq_next     = sq_reg;
        sum_next    = sum_reg;
        asum_next   = asum_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    for (int i = 0; i < 6; i++) begin
                        smp_next[i] = s_tdata[32*i +: 32];
                        // first sample primes the averages
                        if (!primed_reg) begin
                            avg_next[i] = s_tdata[32*i +: 32];
                        end
                    end
                    dt_next     = s_tdata[211:192];
                    primed_next = 1'b1;
                    axis_next   = '0;
                    sum_next    = '0;
                    state_next  = F_MUL;
                end
            end
            F_MUL: begin
                p_next     = $signed({1'b0, alpha_eff}) * diff;
                state_next = F_DIF;
            end
            F_DIF: begin
                avg_next[axis_reg] = avg_reg[axis_reg] + d[31:0];
                dmag_next          = d_abs[32:0];
                state_next         = F_SQR;
            end
            F_SQR: begin
                sq_next    = 66'(dmag_reg) * 66'(dmag_reg);
                state_next = F_ACC;
            end
            F_ACC: begin
                if (axis_reg == 3'd2) begin
                    asum_next = sum_reg + sq_reg;
                    sum_next  = '0;
                end else begin
                    sum_next  = sum_reg + sq_reg;
                end
                if (axis_reg == 3'd5) begin
                    state_next = F_PUSH;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = F_MUL;
                end
            end
            F_PUSH: begin
                if (!queue_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            primed_reg <= 1'b0;
            axis_reg   <= '0;
            for (int i = 0; i < 6; i++) begin
                avg_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            primed_reg <= primed_next;
            axis_reg   <= axis_next;
            avg_reg    <= avg_next;
        end
        smp_reg  <= smp_next;
        dt_reg   <= dt_next;
        p_reg    <= p_next;
        dmag_reg <= dmag_next;
        sq_reg   <= sq_next;
        sum_reg  <= sum_next;
        asum_reg <= asum_next;
    end

endmodule

FILE: hw/rtl/jans_lane.sv
module jans_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  jans_pkg::lane_ctl_t   ctl,
    input  logic [65:0]           sum_sq,
    input  logic [19:0]           dt,
    input  logic [30:0]           limit,
    input  logic [23:0]           ceiling,
    output jans_pkg::lane_stat_t  stat,
    output logic [23:0]           scale
);
    typedef enum logic [3:0] {
        L_IDLE, L_SQRT, L_MUL, L_DIV1, L_CMP, L_DIV2, L_SQR, L_CAP, L_DONE
    } lane_state_t;

    lane_state_t   state_reg, state_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [67:0]   s_reg, s_next;
    logic [36:0]   rem_reg, rem_next;
    logic [33:0]   root_reg, root_next;
    logic [19:0]   dt_reg, dt_next;
    logic [53:0]   q_reg, q_next;
    logic [30:0]   drem_reg, drem_next;
    logic [30:0]   dvs_reg, dvs_next;
    logic [41:0]   sq_reg, sq_next;
    logic [23:0]   scale_reg, scale_next;

    logic [36:0]   rem_sh;
    logic [35:0]   trial;
    logic [31:0]   drem_sh;
    logic          dge;
    logic [30:0]   lim_eff;
    logic [23:0]   ceil_eff;
    logic [35:0]   lim_x32;
    logic [25:0]   s_scaled;

    assign stat.idle = (state_reg == L_IDLE);
    assign stat.done = (state_reg == L_DONE);
    assign scale     = scale_reg;

    // Square root, two bits of the radicand per step
    assign rem_sh = {rem_reg[34:0], s_reg[67:66]};
    assign trial  = {root_reg, 2'b01};

    // Restoring divide, one quotient bit per step
    assign drem_sh = {drem_reg, q_reg[53]};
    assign dge     = (drem_sh >= {1'b0, dvs_reg});

    assign lim_eff  = (limit == '0) ? 31'd1 : limit;
    assign ceil_eff = (ceiling < jans_pkg::ONE_Q16_24) ? jans_pkg::ONE_Q16_24 : ceiling;
    assign lim_x32  = {lim_eff, 5'b0};
    assign s_scaled = sq_reg[41:16];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_next     = s_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        dt_next    = dt_reg;
        q_next     = q_reg;
        drem_next  = drem_reg;
        dvs_next   = dvs_reg;
        sq_next    = sq_reg;
        scale_next = scale_reg;
        case (state_reg)
            L_IDLE: begin
                if (ctl.start) begin
                    s_next     = {2'b0, sum_sq};
                    rem_next   = '0;
                    root_next  = '0;
                    dt_next    = dt;
                    cnt_next   = '0;
                    state_next = L_SQRT;
                end
            end
            L_SQRT: begin
                s_next = {s_reg[65:0], 2'b00};
                if (rem_sh >= {1'b0, trial}) begin
                    rem_next  = rem_sh - {1'b0, trial};
                    root_next = {root_reg[32:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[32:0], 1'b0};
                end
                if (cnt_reg == 6'd33) begin
                    state_next = L_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            L_MUL: begin
                // short interval gives rate zero
                cnt_next  = '0;
                drem_next = '0;
                dvs_next  = {11'b0, dt_reg};
                if (dt_reg > 20'd1) begin
                    q_next     = 54'(root_reg) * 54'(jans_pkg::US_PER_S);
                    state_next = L_DIV1;
                end else begin
                    q_next     = '0;
                    state_next = L_CMP;
                end
            end
            L_DIV1, L_DIV2: begin
                q_next    = {q_reg[52:0], dge};
                drem_next = dge ? 31'(drem_sh - {1'b0, dvs_reg}) : drem_sh[30:0];
                if (cnt_reg == 6'd53) begin
                    state_next = (state_reg == L_DIV1) ? L_CMP : L_SQR;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            L_CMP: begin
                cnt_next  = '0;
                drem_next = '0;
                dvs_next  = lim_eff;
                if (q_reg <= 54'(lim_eff)) begin
                    scale_next = jans_pkg::ONE_Q16_24;
                    state_next = L_DONE;
                end else if (q_reg >= 54'(lim_x32)) begin
                    scale_next = ceil_eff;
                    state_next = L_DONE;
                end else begin
                    // rate below 2^36 here, ratio in Q.16
                    q_next     = {2'b0, q_reg[35:0], 16'b0};
                    state_next = L_DIV2;
                end
            end
            L_SQR: begin
                sq_next    = 42'(q_reg[20:0]) * 42'(q_reg[20:0]);
                state_next = L_CAP;
            end
            L_CAP: begin
                scale_next = (s_scaled > 26'(ceil_eff)) ? ceil_eff : s_scaled[23:0];
                state_next = L_DONE;
            end
            L_DONE: begin
                if (ctl.ack) begin
                    state_next = L_IDLE;
                end
            end
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        s_reg     <= s_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        dt_reg    <= dt_next;
        q_reg     <= q_next;
        drem_reg  <= drem_next;
        dvs_reg   <= dvs_next;
        sq_reg    <= sq_next;
        scale_reg <= scale_next;
    end

endmodule

FILE: hw/rtl/jerk_adaptive_noise_scaler.sv
// Path from input transaction to m_tvalid: the front (to the queue), the queue pop, the lanes and
// the output register; short intervals and out-of-range ratios end sooner.
// Each back lane works on one item at a time: 34-step square root and two
// 54-step restoring divides plus control steps; the front takes one sample at a time until it pushes.
// A two-entry queue lets the front accept the next sample while the lanes work.
// Reset (aresetn low, synchronous): registers at defaults, averages unprimed, queue empty.
module jerk_adaptive_noise_scaler #(
    parameter int QUEUE_DEPTH = jans_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata, low bit up: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (32 each),
    // dt_us (20), 4 zero bits
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [215:0] s_tdata,
    // m_tdata, low bit up: accel_scale (24), gyro_scale (24)
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [jans_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]  cfg_data
);
    logic [16:0]  alpha_reg;
    logic [30:0]  jlim_reg;
    logic [30:0]  alim_reg;
    logic [23:0]  ceil_reg;
    logic         m_valid_reg, m_valid_next;
    logic [47:0]  m_data_reg, m_data_next;

    logic                 push, q_full, q_empty, q_pop;
    jans_pkg::qent_t      push_data, q_head;
    jans_pkg::lane_ctl_t  ctl;
    jans_pkg::lane_stat_t acc_stat, gyr_stat;
    logic [23:0]          acc_scale, gyr_scale;
    logic                 out_load;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= jans_pkg::RST_EMA_ALPHA;
            jlim_reg  <= jans_pkg::RST_JERK_LIM;
            alim_reg  <= jans_pkg::RST_ANG_LIM;
            ceil_reg  <= jans_pkg::RST_CEILING;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                jans_pkg::REG_EMA_ALPHA:  alpha_reg <= cfg_data[16:0];
                jans_pkg::REG_JERK_LIMIT: jlim_reg  <= cfg_data[30:0];
                jans_pkg::REG_ANG_LIMIT:  alim_reg  <= cfg_data[30:0];
                jans_pkg::REG_CEILING:    ceil_reg  <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    jans_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .alpha      (alpha_reg),
        .push       (push),
        .push_data  (push_data),
        .queue_full (q_full)
    );

    jans_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // Start both lanes together when both are free
    assign q_pop     = !q_empty && acc_stat.idle && gyr_stat.idle;
    assign out_load  = acc_stat.done && gyr_stat.done && (!m_valid_reg || m_tready);
    assign ctl.start = q_pop;
    assign ctl.ack   = out_load;

    jans_lane u_lane_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sum_sq  (q_head.acc_sq),
        .dt      (q_head.dt),
        .limit   (jlim_reg),
        .ceiling (ceil_reg),
        .stat    (acc_stat),
        .scale   (acc_scale)
    );

    jans_lane u_lane_gyr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sum_sq  (q_head.gyr_sq),
        .dt      (q_head.dt),
        .limit   (alim_reg),
        .ceiling (ceil_reg),
        .stat    (gyr_stat),
        .scale   (gyr_scale)
    );

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {gyr_scale, acc_scale};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: hw/rtl/jans_checker.sv
`include "assert_macros.svh"

module jans_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata
);
    // stalled result stays offered
    `CHK_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    // scales never fall below 1.0
    `CHK_ASSERT(a_acc_min, aclk, aresetn, m_tvalid |-> m_tdata[23:0] >= 24'd65536)
    `CHK_ASSERT(a_gyr_min, aclk, aresetn, m_tvalid |-> m_tdata[47:24] >= 24'd65536)
    // front is busy the cycle after taking a sample
    `CHK_ASSERT(a_front_busy, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    // no result comes out during reset
    `CHK_ASSERT_ALWAYS(a_rst_quiet, aclk, !aresetn |=> !m_tvalid)

endmodule

bind jerk_adaptive_noise_scaler jans_checker u_jans_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
